// ----- design/fidl_pkg.sv -----
// Shared types and constants for the frame input delay line.
// No dependencies; imported by fidl_cfg, fidl_queue and the top level.
`default_nettype none

package fidl_pkg;

    localparam int DEPTH_W = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Pad word that means "no input".
    localparam int NEUTRAL_WORD = 5;

    // Register word index, taken from paddr[2].
    localparam logic REG_DELAY_DEPTH = 1'b0;
    localparam logic REG_BYPASS      = 1'b1;

    typedef struct packed {
        logic [DEPTH_W-1:0] delay_depth;
        logic               bypass_when_frozen;
    } cfg_t;

endpackage

`default_nettype wire

// ----- design/fidl_cfg.sv -----
// APB-style configuration registers for the frame input delay line.
// Depends on fidl_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module fidl_cfg
    import fidl_pkg::*;
#(
    parameter int MAX_DELAY = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               bypass_reg;
    logic               bypass_next;
    logic               wr_en;
    logic [DEPTH_W-1:0] wr_depth;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign wr_depth = pwdata[DEPTH_W-1:0];

    always_comb
    begin
        depth_next  = depth_reg;
        bypass_next = bypass_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_DELAY_DEPTH:
                begin
                    // Saturate depths beyond the line's capacity.
                    if (32'(wr_depth) > 32'(MAX_DELAY))
                        depth_next = DEPTH_W'(MAX_DELAY);
                    else
                        depth_next = wr_depth;
                end
                REG_BYPASS:
                begin
                    bypass_next = pwdata[0];
                end
                default:
                begin
                    depth_next = depth_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            depth_reg  <= depth_next;
            bypass_reg <= bypass_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_DELAY_DEPTH: prdata = DATA_W'(depth_reg);
            REG_BYPASS:      prdata = DATA_W'(bypass_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.delay_depth        = depth_reg;
    assign cfg.bypass_when_frozen = bypass_reg;

endmodule

`default_nettype wire

// ----- design/fidl_queue.sv -----
// Ring-buffer delay queue and frame tracking for player 0 pad words.
// Depends on fidl_pkg for cfg_t and the neutral word constant.
`default_nettype none

module fidl_queue
    import fidl_pkg::*;
#(
    parameter int MAX_DELAY = 10,
    parameter int WORD_BITS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 step,
    input  wire logic                 player,
    input  wire logic [WORD_BITS-1:0] pad_word,
    input  wire logic [31:0]          frame_number,
    input  wire logic                 mode_active,
    input  wire logic                 frozen,
    output logic      [WORD_BITS-1:0] result
);

    localparam int SLOTS = MAX_DELAY + 1;
    localparam int PTR_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(MAX_DELAY + 1);
    localparam int CW    = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
    localparam int SW    = PTR_W + 1;

    logic [WORD_BITS-1:0] words_reg [SLOTS];

    logic [PTR_W-1:0]     head_reg;
    logic [PTR_W-1:0]     head_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [WORD_BITS-1:0] frame_result_reg;
    logic [WORD_BITS-1:0] frame_result_next;
    logic [31:0]          prev_frame_reg;
    logic [31:0]          prev_frame_next;
    logic                 seen_reg;
    logic                 seen_next;

    logic             eligible;
    logic             repeat_frame;
    logic             jump;
    logic [CW-1:0]    depth_x;
    logic [CW-1:0]    cnt0;
    logic [CW-1:0]    cnt1;
    logic [CW-1:0]    drop;
    logic [PTR_W-1:0] head1;
    logic [PTR_W-1:0] push_ptr;
    logic             full;
    logic             push_en;

    // Ring pointer plus an offset below SLOTS, wrapped with one subtract.
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [PTR_W-1:0] ofs);
        logic [SW-1:0] s;
        s = SW'(ptr) + SW'(ofs);
        if (s >= SW'(SLOTS))
            s = s - SW'(SLOTS);
        return s[PTR_W-1:0];
    endfunction

    assign eligible = (cfg.delay_depth != '0) && !(cfg.bypass_when_frozen && frozen)
                      && mode_active;
    assign repeat_frame = seen_reg && (frame_number == prev_frame_reg);
    assign jump         = seen_reg && (frame_number != (prev_frame_reg + 32'd1));

    assign depth_x = CW'(cfg.delay_depth);
    assign cnt0    = jump ? '0 : CW'(count_reg);
    assign drop    = (cnt0 > depth_x) ? (cnt0 - depth_x) : '0;
    assign cnt1    = (cnt0 > depth_x) ? depth_x : cnt0;
    assign head1   = ring_add(head_reg, PTR_W'(drop));
    assign push_ptr = ring_add(head1, PTR_W'(cnt1));
    // Line is full after trimming: the oldest word leaves as this frame's output.
    assign full    = (cnt1 == depth_x);

    always_comb
    begin
        head_next         = head_reg;
        count_next        = count_reg;
        frame_result_next = frame_result_reg;
        prev_frame_next   = prev_frame_reg;
        seen_next         = seen_reg;
        push_en           = 1'b0;
        result            = pad_word;

        if (player)
        begin
            result = pad_word;
        end
        else if (!eligible)
        begin
            count_next        = '0;
            frame_result_next = WORD_BITS'(NEUTRAL_WORD);
            prev_frame_next   = '0;
            seen_next         = 1'b0;
            result            = pad_word;
        end
        else if (repeat_frame)
        begin
            result = frame_result_reg;
        end
        else
        begin
            push_en         = 1'b1;
            prev_frame_next = frame_number;
            seen_next       = 1'b1;
            if (full)
            begin
                head_next         = ring_add(head1, PTR_W'(1));
                count_next        = CNT_W'(cnt1);
                frame_result_next = words_reg[head1];
            end
            else
            begin
                head_next         = head1;
                count_next        = CNT_W'(cnt1 + CW'(1));
                frame_result_next = WORD_BITS'(NEUTRAL_WORD);
            end
            result = frame_result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && push_en)
            words_reg[push_ptr] <= pad_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            count_reg        <= '0;
            frame_result_reg <= WORD_BITS'(NEUTRAL_WORD);
            prev_frame_reg   <= '0;
            seen_reg         <= 1'b0;
        end
        else if (step)
        begin
            head_reg         <= head_next;
            count_reg        <= count_next;
            frame_result_reg <= frame_result_next;
            prev_frame_reg   <= prev_frame_next;
            seen_reg         <= seen_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_DELAY))
        else $error("queue count beyond capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) < 32'(SLOTS))
        else $error("queue head outside ring");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (count_reg == '0))
        else $error("queue holds words while no frame is tracked");

    a_repeat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && !player && eligible && repeat_frame
        |=> $stable(count_reg) && $stable(head_reg) && $stable(frame_result_reg))
        else $error("repeated frame changed queue state");

endmodule

`default_nettype wire

// ----- design/frame_input_delay_line_core.sv -----
// Top level of the frame input delay line: input register, delay queue, result register.
// Depends on fidl_pkg, fidl_cfg and fidl_queue.
//
// Takes one item per clock while the result register is not stalled and returns one pad_out
// item per item, held first in the input register and then in the result register. The queue
// update is a single ring-buffer step per item, so items can follow back to back; a
// stalled result holds the input register, and in_ready then follows out_ready.
// Player 1 words pass through; player 0 words are delayed by delay_depth frames, with
// neutral (5) output while the line fills. Write configuration only while idle.
`default_nettype none

module frame_input_delay_line_core
    import fidl_pkg::*;
#(
    parameter int MAX_DELAY = 10,
    parameter int WORD_BITS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic      [DATA_W-1:0]    prdata,
    output logic                      pready,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 player,
    input  wire logic [WORD_BITS-1:0] pad_word,
    input  wire logic [31:0]          frame_number,
    input  wire logic                 mode_active,
    input  wire logic                 frozen,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [WORD_BITS-1:0] pad_out
);

    cfg_t cfg;

    logic                 in_valid_reg;
    logic                 player_reg;
    logic [WORD_BITS-1:0] pad_word_reg;
    logic [31:0]          frame_number_reg;
    logic                 mode_active_reg;
    logic                 frozen_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] pad_out_reg;
    logic [WORD_BITS-1:0] result;
    logic                 advance;
    logic                 step;
    logic                 in_take;

    fidl_cfg #(
        .MAX_DELAY (MAX_DELAY)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fidl_queue #(
        .MAX_DELAY (MAX_DELAY),
        .WORD_BITS (WORD_BITS)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step         (step),
        .player       (player_reg),
        .pad_word     (pad_word_reg),
        .frame_number (frame_number_reg),
        .mode_active  (mode_active_reg),
        .frozen       (frozen_reg),
        .result       (result)
    );

    // Result register is free or being drained this cycle.
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            player_reg       <= player;
            pad_word_reg     <= pad_word;
            frame_number_reg <= frame_number;
            mode_active_reg  <= mode_active;
            frozen_reg       <= frozen;
        end
        if (step)
            pad_out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign pad_out   = pad_out_reg;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for frame_input_delay_line_core: a directed table, then random phases.
// Depends on fidl_pkg and the core; a built-in delay line model predicts each pad_out item without a typed expectation.

module tb_top
    import fidl_pkg::*;
();

    localparam int MAX_DELAY   = 10;
    localparam int WORD_BITS   = 10;
    localparam int LINE_SLOTS  = MAX_DELAY + 1;
    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD   = 60;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 103;

    typedef logic [WORD_BITS-1:0] pad_t;

    localparam pad_t NEUTRAL_PAD = pad_t'(NEUTRAL_WORD);

    typedef struct packed {
        logic        is_write;
        logic        reg_sel;
        logic [31:0] value;
        logic        player_id;
        pad_t        word;
        logic [31:0] frame;
        logic        active;
        logic        frz;
        logic        has_exp;
        pad_t        exp_pad;
    } step_t;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              player       = 1'b0;
    pad_t              pad_word     = '0;
    logic [31:0]       frame_number = '0;
    logic              mode_active  = 1'b0;
    logic              frozen       = 1'b0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    pad_t              pad_out;

    // Hand-computed expectation travelling with the item on offer.
    logic              typed_known  = 1'b0;
    pad_t              typed_pad    = '0;

    // Delay line model state and its copy of the registers.
    int unsigned       depth_cfg    = 0;
    logic              bypass_cfg   = 1'b0;
    pad_t              line_words [LINE_SLOTS];
    int unsigned       line_count   = 0;
    pad_t              line_result  = NEUTRAL_PAD;
    logic [31:0]       line_prev    = '0;
    logic              line_seen    = 1'b0;

    pad_t              pad_expect_q [$];
    step_t             plan [$];
    int                fault_count  = 0;
    int                quiet_cycles = 0;
    int                idle_odds    = 30;
    logic              hold_off_req = 1'b0;

    frame_input_delay_line_core #(
        .MAX_DELAY (MAX_DELAY),
        .WORD_BITS (WORD_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .player       (player),
        .pad_word     (pad_word),
        .frame_number (frame_number),
        .mode_active  (mode_active),
        .frozen       (frozen),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pad_out      (pad_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pad_t drop_oldest();
        pad_t head;
        head = line_words[0];
        for (int i = 1; i < line_count; i++)
            line_words[i-1] = line_words[i];
        if (line_count > 0)
            line_count--;
        return head;
    endfunction

    function automatic pad_t predict_pad(input logic who, input pad_t word,
                                         input logic [31:0] frame,
                                         input logic active, input logic frz);
        pad_t held;
        held = NEUTRAL_PAD;
        if (who)
            return word;
        // Line not eligible: clear it and pass the word through.
        if (depth_cfg == 0 || (bypass_cfg && frz) || !active)
        begin
            line_count  = 0;
            line_result = NEUTRAL_PAD;
            line_prev   = '0;
            line_seen   = 1'b0;
            return word;
        end
        if (line_seen && frame == line_prev)
            return line_result;
        // Anything but the next frame flushes the line.
        if (line_seen && frame != line_prev + 32'd1)
            line_count = 0;
        // Drop leftovers from a larger depth, oldest first.
        while (line_count > depth_cfg)
            void'(drop_oldest());
        if (line_count < LINE_SLOTS)
        begin
            line_words[line_count] = word;
            line_count++;
        end
        if (line_count > depth_cfg)
            held = drop_oldest();
        line_result = held;
        line_prev   = frame;
        line_seen   = 1'b1;
        return held;
    endfunction

    function automatic void report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] check failed: %s", $time, msg);
    endfunction

    always @(posedge clk)
    begin : scoreboard
        pad_t want;
        pad_t guess;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pad_expect_q.size() == 0)
                    report_fault($sformatf("pad_out item %03h with none expected", pad_out));
                else
                begin
                    want = pad_expect_q.pop_front();
                    if (pad_out !== want)
                        report_fault($sformatf("pad_out expected %03h, got %03h",
                                               want, pad_out));
                end
            end
            if (in_valid && in_ready)
            begin
                guess = predict_pad(player, pad_word, frame_number, mode_active, frozen);
                pad_expect_q.push_back(typed_known ? typed_pad : guess);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin : receiver
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic offer_pad(input step_t s);
        in_valid     <= 1'b1;
        player       <= s.player_id;
        pad_word     <= s.word;
        frame_number <= s.frame;
        mode_active  <= s.active;
        frozen       <= s.frz;
        typed_known  <= s.has_exp;
        typed_pad    <= s.exp_pad;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic idle_gap();
        if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Hold the sender until every expected item has come out.
    task automatic drain_line();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pad_expect_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        drain_line();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_DELAY_DEPTH)
            depth_cfg = (value[3:0] > MAX_DELAY) ? MAX_DELAY : value[3:0];
        else
            bypass_cfg = value[0];
    endtask

    function automatic void add_write(input logic sel, input logic [31:0] value);
        step_t s;
        s          = '0;
        s.is_write = 1'b1;
        s.reg_sel  = sel;
        s.value    = value;
        plan.push_back(s);
    endfunction

    function automatic void add_pad(input logic who, input pad_t word, input logic [31:0] frame,
                                    input logic active, input logic frz,
                                    input logic has_exp, input pad_t exp_pad);
        step_t s;
        s           = '0;
        s.player_id = who;
        s.word      = word;
        s.frame     = frame;
        s.active    = active;
        s.frz       = frz;
        s.has_exp   = has_exp;
        s.exp_pad   = exp_pad;
        plan.push_back(s);
    endfunction

    initial
    begin : stimulus
        step_t       s;
        logic [31:0] frame_ctr;
        int          roll;
        int unsigned depth_plan [PHASES];

        depth_plan = '{15, 1, 10, 0, 4, 11, 2, 7};

        // Depth zero after reset: both players pass through.
        add_pad(1'b0, 10'h3FF, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 10'h3FF);
        add_pad(1'b1, 10'h000, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 10'h000);
        // Depth above range saturates; neutral while filling, across the frame wrap.
        add_write(REG_DELAY_DEPTH, 32'h0000_000F);
        add_write(REG_BYPASS, 32'h0000_0001);
        add_pad(1'b0, 10'h2AA, 32'hFFFF_FFFE, 1'b1, 1'b0, 1'b1, NEUTRAL_PAD);
        add_pad(1'b0, 10'h155, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, NEUTRAL_PAD);
        add_pad(1'b0, 10'h001, 32'h0000_0000, 1'b1, 1'b0, 1'b1, NEUTRAL_PAD);
        add_pad(1'b0, 10'h3FF, 32'h0000_0000, 1'b1, 1'b0, 1'b1, NEUTRAL_PAD);
        add_pad(1'b1, 10'h200, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 10'h200);
        // Frozen with bypass clears the line.
        add_pad(1'b0, 10'h0F0, 32'h0000_0001, 1'b1, 1'b1, 1'b1, 10'h0F0);
        // One frame of delay, repeated frame, frame jump, inactive mode.
        add_write(REG_DELAY_DEPTH, 32'h0000_0001);
        add_pad(1'b0, 10'h111, 32'd100, 1'b1, 1'b0, 1'b1, NEUTRAL_PAD);
        add_pad(1'b0, 10'h222, 32'd101, 1'b1, 1'b0, 1'b1, 10'h111);
        add_pad(1'b0, 10'h333, 32'd101, 1'b1, 1'b0, 1'b1, 10'h111);
        add_pad(1'b0, 10'h044, 32'd103, 1'b1, 1'b0, 1'b1, NEUTRAL_PAD);
        add_pad(1'b0, 10'h055, 32'd104, 1'b1, 1'b0, 1'b1, 10'h044);
        add_pad(1'b0, 10'h3C3, 32'd105, 1'b0, 1'b0, 1'b1, 10'h3C3);
        // Without bypass, frozen frames are still delayed.
        add_write(REG_BYPASS, 32'h0000_0000);
        add_pad(1'b0, 10'h0A0, 32'd7, 1'b1, 1'b1, 1'b1, NEUTRAL_PAD);
        add_pad(1'b0, 10'h0B0, 32'd8, 1'b1, 1'b1, 1'b1, 10'h0A0);
        // Raise the depth, then lower it so leftovers get trimmed.
        add_write(REG_DELAY_DEPTH, 32'hFFFF_FFF4);
        add_pad(1'b0, 10'h0C1, 32'd9, 1'b1, 1'b0, 1'b0, '0);
        add_pad(1'b0, 10'h0C2, 32'd10, 1'b1, 1'b0, 1'b0, '0);
        add_pad(1'b0, 10'h0C3, 32'd11, 1'b1, 1'b0, 1'b0, '0);
        add_pad(1'b0, 10'h0C4, 32'd12, 1'b1, 1'b0, 1'b0, '0);
        add_write(REG_DELAY_DEPTH, 32'h0000_0012);
        add_pad(1'b0, 10'h0C5, 32'd13, 1'b1, 1'b0, 1'b0, '0);
        add_pad(1'b0, 10'h3FF, 32'd14, 1'b1, 1'b0, 1'b0, '0);
        add_pad(1'b0, 10'h000, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].is_write)
                write_reg(plan[k].reg_sel, plan[k].value);
            else
            begin
                idle_gap();
                offer_pad(plan[k]);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_odds = (ph == PHASES - 1) ? 0 : (ph % 3) * 25;
            write_reg(REG_DELAY_DEPTH, {28'($urandom()), 4'(depth_plan[ph])});
            write_reg(REG_BYPASS, {31'($urandom()), 1'(ph % 2)});
            frame_ctr = (ph == 2) ? 32'hFFFF_FFF8 : $urandom();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == 10)
                    hold_off_req = 1'b1;
                if (ph == 5 && n == 50)
                    drain_line();
                s        = '0;
                s.word   = pad_t'($urandom_range(0, 1023));
                s.active = 1'b1;
                s.frz    = ($urandom_range(0, 29) == 0);
                roll     = $urandom_range(0, 99);
                if (roll < 20)
                begin
                    s.player_id = 1'b1;
                    s.frame     = $urandom();
                    s.active    = 1'($urandom_range(0, 1));
                    s.frz       = 1'($urandom_range(0, 1));
                end
                else
                begin
                    // Mostly consecutive frames; 80..89 repeat the last frame.
                    roll = $urandom_range(0, 99);
                    if (roll >= 97)
                        s.active = 1'b0;
                    else if (roll >= 95)
                        frame_ctr = $urandom();
                    else if (roll >= 93)
                        frame_ctr = frame_ctr - $urandom_range(1, 3);
                    else if (roll >= 90)
                        frame_ctr = frame_ctr + $urandom_range(2, 9);
                    else if (roll < 80)
                        frame_ctr = frame_ctr + 32'd1;
                    s.frame = frame_ctr;
                end
                idle_gap();
                offer_pad(s);
            end
        end

        drain_line();
        if (fault_count == 0 && pad_expect_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
